### rtl/sgpb_pkg.sv
// ----------------------------------------------------------------------------
// sgpb_pkg
// Types, constants and font functions shared by the glyph page byte generator.
// ----------------------------------------------------------------------------
package sgpb_pkg;

   // one glyph: five cell columns of five cells, bit 0 of a column at the top
   typedef logic [4:0][4:0] glyph_type;

   // work item passed from the front end to the back end
   typedef struct packed {
      logic [2:0] page;
      logic [6:0] column;
      glyph_type  glyph;
   } qentry_type;

   // configuration register select (paddr bit 2)
   localparam logic CSR_LETTERS_ENABLE = 1'b0;

   localparam logic [5:0] GLYPH_COLON = 6'd10;
   localparam logic [5:0] GLYPH_DASH  = 6'd11;
   localparam logic [5:0] GLYPH_DOT   = 6'd12;
   localparam logic [5:0] GLYPH_BLANK = 6'd13;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   // letter glyphs start at 14: index = code - 'A' + 14, code - 'a' + 14
   localparam logic [7:0] UPPER_BIAS  = 8'd51;
   localparam logic [7:0] LOWER_BIAS  = 8'd83;

   localparam logic [3:0] LAST_OFFSET = 4'd14;
   localparam logic [2:0] LAST_CELL   = 3'd4;
   localparam logic [1:0] LAST_SUB    = 2'd2;

   function automatic logic [5:0] glyph_index(input logic [7:0] code,
                                              input logic       letters);
      logic [7:0] diff;
      begin
         glyph_index = GLYPH_BLANK;
         if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            diff = code - CHAR_ZERO;
            glyph_index = diff[5:0];
         end else if (code == CHAR_COLON) begin
            glyph_index = GLYPH_COLON;
         end else if (code == CHAR_DASH) begin
            glyph_index = GLYPH_DASH;
         end else if (code == CHAR_DOT) begin
            glyph_index = GLYPH_DOT;
         end else if (code == CHAR_SPACE) begin
            glyph_index = GLYPH_BLANK;
         end else if (letters && code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
            diff = code - UPPER_BIAS;
            glyph_index = diff[5:0];
         end else if (letters && code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
            diff = code - LOWER_BIAS;
            glyph_index = diff[5:0];
         end
      end
   endfunction

   function automatic glyph_type glyph_cols(input logic [4:0] c0, input logic [4:0] c1,
                                            input logic [4:0] c2, input logic [4:0] c3,
                                            input logic [4:0] c4);
      glyph_cols = {c4, c3, c2, c1, c0};
   endfunction

   function automatic glyph_type font_rom(input logic [5:0] idx);
      case (idx)
         6'd0:  font_rom = glyph_cols(5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E);
         6'd1:  font_rom = glyph_cols(5'h00, 5'h12, 5'h1F, 5'h10, 5'h00);
         6'd2:  font_rom = glyph_cols(5'h12, 5'h19, 5'h15, 5'h15, 5'h12);
         6'd3:  font_rom = glyph_cols(5'h0A, 5'h11, 5'h15, 5'h15, 5'h0A);
         6'd4:  font_rom = glyph_cols(5'h07, 5'h04, 5'h04, 5'h1F, 5'h04);
         6'd5:  font_rom = glyph_cols(5'h17, 5'h15, 5'h15, 5'h15, 5'h09);
         6'd6:  font_rom = glyph_cols(5'h0E, 5'h15, 5'h15, 5'h15, 5'h08);
         6'd7:  font_rom = glyph_cols(5'h01, 5'h19, 5'h05, 5'h03, 5'h01);
         6'd8:  font_rom = glyph_cols(5'h0A, 5'h15, 5'h15, 5'h15, 5'h0A);
         6'd9:  font_rom = glyph_cols(5'h02, 5'h15, 5'h15, 5'h15, 5'h0E);
         6'd10: font_rom = glyph_cols(5'h00, 5'h00, 5'h0A, 5'h00, 5'h00);
         6'd11: font_rom = glyph_cols(5'h00, 5'h04, 5'h04, 5'h04, 5'h00);
         6'd12: font_rom = glyph_cols(5'h00, 5'h00, 5'h10, 5'h00, 5'h00);
         6'd14: font_rom = glyph_cols(5'h1E, 5'h05, 5'h05, 5'h05, 5'h1E);
         6'd15: font_rom = glyph_cols(5'h1F, 5'h15, 5'h15, 5'h15, 5'h0A);
         6'd16: font_rom = glyph_cols(5'h0E, 5'h11, 5'h11, 5'h11, 5'h0A);
         6'd17: font_rom = glyph_cols(5'h1F, 5'h11, 5'h11, 5'h11, 5'h0E);
         6'd18: font_rom = glyph_cols(5'h1F, 5'h15, 5'h15, 5'h15, 5'h11);
         6'd19: font_rom = glyph_cols(5'h1F, 5'h05, 5'h05, 5'h05, 5'h01);
         6'd20: font_rom = glyph_cols(5'h0E, 5'h11, 5'h15, 5'h15, 5'h0C);
         6'd21: font_rom = glyph_cols(5'h1F, 5'h04, 5'h04, 5'h04, 5'h1F);
         6'd22: font_rom = glyph_cols(5'h00, 5'h11, 5'h1F, 5'h11, 5'h00);
         6'd23: font_rom = glyph_cols(5'h08, 5'h10, 5'h10, 5'h10, 5'h0F);
         6'd24: font_rom = glyph_cols(5'h1F, 5'h04, 5'h0A, 5'h11, 5'h00);
         6'd25: font_rom = glyph_cols(5'h1F, 5'h10, 5'h10, 5'h10, 5'h10);
         6'd26: font_rom = glyph_cols(5'h1F, 5'h02, 5'h04, 5'h02, 5'h1F);
         6'd27: font_rom = glyph_cols(5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F);
         6'd28: font_rom = glyph_cols(5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E);
         6'd29: font_rom = glyph_cols(5'h1F, 5'h05, 5'h05, 5'h05, 5'h02);
         6'd30: font_rom = glyph_cols(5'h0E, 5'h11, 5'h19, 5'h11, 5'h1E);
         6'd31: font_rom = glyph_cols(5'h1F, 5'h05, 5'h05, 5'h0D, 5'h12);
         6'd32: font_rom = glyph_cols(5'h12, 5'h15, 5'h15, 5'h15, 5'h09);
         6'd33: font_rom = glyph_cols(5'h01, 5'h01, 5'h1F, 5'h01, 5'h01);
         6'd34: font_rom = glyph_cols(5'h0F, 5'h10, 5'h10, 5'h10, 5'h0F);
         6'd35: font_rom = glyph_cols(5'h03, 5'h0C, 5'h10, 5'h0C, 5'h03);
         6'd36: font_rom = glyph_cols(5'h0F, 5'h10, 5'h0C, 5'h10, 5'h0F);
         6'd37: font_rom = glyph_cols(5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11);
         6'd38: font_rom = glyph_cols(5'h01, 5'h02, 5'h1C, 5'h02, 5'h01);
         6'd39: font_rom = glyph_cols(5'h19, 5'h15, 5'h15, 5'h15, 5'h13);
         default: font_rom = '0;
      endcase
   endfunction

   // spread one cell column over two pages: each cell row becomes three pixel rows
   function automatic logic [7:0] scale_column(input logic [4:0] cells,
                                               input logic       lower);
      if (lower) begin
         scale_column = {1'b0, {3{cells[4]}}, {3{cells[3]}}, cells[2]};
      end else begin
         scale_column = {{2{cells[2]}}, {3{cells[1]}}, {3{cells[0]}}};
      end
   endfunction

endpackage

### rtl/scaled_glyph_page_byte_generator.sv
// ----------------------------------------------------------------------------
// scaled_glyph_page_byte_generator
// Character to 15x15 scaled glyph column bytes for a paged pixel display.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one beat per character, carrying start column,
//   top page and character code. The front end classifies the code, fetches
//   its 5x5 glyph and drops it into a small queue.
//   Response channel (rsp_*): thirty beats per character, fifteen column
//   bytes for the top page then fifteen for the page below, tagged with page,
//   base column and column offset; rsp_last marks the thirtieth beat.
//   Flow: a request beat is written into the queue, and the back end then
//   registers each response beat in its output register. The back end emits
//   one column byte per cycle while rsp_stall is low; requests are taken
//   while the queue has room, so the next character is waiting when the
//   current one ends and beats run back to back.
//   rsp_stall holds the output register and freezes the column walk; once the
//   queue fills, req_stall rises.
//   Reset clears the queue and the column walk and sets letters_enable to 1.
//   CSR: letters_enable at byte address 0 (bit 0).
// ----------------------------------------------------------------------------
module scaled_glyph_page_byte_generator #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [6:0]  req_start_column,
   input  logic [2:0]  req_top_page,
   input  logic [7:0]  req_char_code,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_target_page,
   output logic [6:0]  rsp_base_column,
   output logic [3:0]  rsp_column_offset,
   output logic [7:0]  rsp_pixel_byte,
   output logic        rsp_last,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                 letters_enable_ff, letters_enable_in;
   logic                 csr_write;
   logic                 queue_full;
   logic                 push;
   logic                 pop;
   logic                 head_valid;
   sgpb_pkg::qentry_type push_entry;
   sgpb_pkg::qentry_type head_entry;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      letters_enable_in = letters_enable_ff;
      if (csr_write && csr_paddr[2] == sgpb_pkg::CSR_LETTERS_ENABLE) begin
         letters_enable_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letters_enable_ff <= 1'b1;
      end else begin
         letters_enable_ff <= letters_enable_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == sgpb_pkg::CSR_LETTERS_ENABLE) begin
         csr_prdata = {31'd0, letters_enable_ff};
      end
   end

   sgpb_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_column (req_start_column),
      .req_top_page     (req_top_page),
      .req_char_code    (req_char_code),
      .letters_enable   (letters_enable_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_entry       (push_entry)
   );

   sgpb_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sgpb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_target_page   (rsp_target_page),
      .rsp_base_column   (rsp_base_column),
      .rsp_column_offset (rsp_column_offset),
      .rsp_pixel_byte    (rsp_pixel_byte),
      .rsp_last          (rsp_last)
   );

endmodule

### rtl/sgpb_front.sv
// ----------------------------------------------------------------------------
// sgpb_front
// Accepts request beats, classifies the character and fetches its glyph.
// ----------------------------------------------------------------------------
module sgpb_front (
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [6:0]           req_start_column,
   input  logic [2:0]           req_top_page,
   input  logic [7:0]           req_char_code,
   input  logic                 letters_enable,
   input  logic                 queue_full,
   output logic                 push,
   output sgpb_pkg::qentry_type push_entry
);

   logic [5:0] glyph_idx;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign glyph_idx = sgpb_pkg::glyph_index(req_char_code, letters_enable);

   always_comb begin
      push_entry.page   = req_top_page;
      push_entry.column = req_start_column;
      push_entry.glyph  = sgpb_pkg::font_rom(glyph_idx);
   end

endmodule

### rtl/sgpb_queue.sv
// ----------------------------------------------------------------------------
// sgpb_queue
// Short first-in first-out queue of glyph work items between front and back.
// ----------------------------------------------------------------------------
module sgpb_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sgpb_pkg::qentry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output sgpb_pkg::qentry_type head_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   sgpb_pkg::qentry_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("queue popped while empty");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");
`endif

endmodule

### rtl/sgpb_back.sv
// ----------------------------------------------------------------------------
// sgpb_back
// Walks the head glyph column by column and drives the response beats.
// ----------------------------------------------------------------------------
module sgpb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  sgpb_pkg::qentry_type head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_target_page,
   output logic [6:0]           rsp_base_column,
   output logic [3:0]           rsp_column_offset,
   output logic [7:0]           rsp_pixel_byte,
   output logic                 rsp_last
);

   logic       half_ff, half_in;
   logic [2:0] cell_ff, cell_in;
   logic [1:0] sub_ff, sub_in;
   logic [3:0] offset_ff, offset_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] page_ff, page_in;
   logic [6:0] column_ff, column_in;
   logic [3:0] col_off_ff, col_off_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   logic advance;
   logic fire;
   logic end_of_half;

   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign fire        = advance && head_valid;
   assign end_of_half = (offset_ff == sgpb_pkg::LAST_OFFSET);
   assign pop         = fire && half_ff && end_of_half;

   always_comb begin
      half_in      = half_ff;
      cell_in      = cell_ff;
      sub_in       = sub_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff;
      page_in      = page_ff;
      column_in    = column_ff;
      col_off_in   = col_off_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         page_in      = head_entry.page + {2'b00, half_ff};
         column_in    = head_entry.column;
         col_off_in   = offset_ff;
         byte_in      = sgpb_pkg::scale_column(head_entry.glyph[cell_ff], half_ff);
         last_in      = half_ff && end_of_half;
         if (end_of_half) begin
            // flip to the other page, or wrap to the next item
            half_in   = !half_ff;
            cell_in   = '0;
            sub_in    = '0;
            offset_in = '0;
         end else begin
            offset_in = offset_ff + 1'b1;
            if (sub_ff == sgpb_pkg::LAST_SUB) begin
               sub_in  = '0;
               cell_in = cell_ff + 1'b1;
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= 1'b0;
         cell_ff      <= '0;
         sub_ff       <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         half_ff      <= half_in;
         cell_ff      <= cell_in;
         sub_ff       <= sub_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      column_ff  <= column_in;
      col_off_ff <= col_off_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_target_page   = page_ff;
   assign rsp_base_column   = column_ff;
   assign rsp_column_offset = col_off_ff;
   assign rsp_pixel_byte    = byte_ff;
   assign rsp_last          = last_ff;

`ifndef NO_ASSERTIONS
   a_counters_in_range: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= sgpb_pkg::LAST_OFFSET && cell_ff <= sgpb_pkg::LAST_CELL &&
      sub_ff <= sgpb_pkg::LAST_SUB)
      else $error("column counters out of range");

   a_cell_tracks_offset: assert property (@(posedge clock) disable iff (reset)
      offset_ff == 4'({2'b00, cell_ff} * 4'd3 + {2'b00, sub_ff}))
      else $error("cell column and offset disagree");

   a_last_on_lower_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last) |-> col_off_ff == sgpb_pkg::LAST_OFFSET)
      else $error("last beat not at final column");

   a_pop_only_at_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid_ff && rsp_last))
      else $error("item released before its final beat");
`endif

endmodule
